[src/gbfd_pkg.sv]
// Shared types, constants and the CRC-16 byte step for the binary frame deframer.
// Depends on nothing; every other file imports it.
`default_nettype none

package gbfd_pkg;

  // Longest frame in bytes before it is cut off
  localparam int MAX_FRAME = 512;
  // Frame byte counter width: must hold MAX_FRAME itself
  localparam int POS_W = $clog2(MAX_FRAME + 1);
  // Width used when comparing the counter with the 16-bit length field
  localparam int CMP_W = (POS_W > 16) ? POS_W : 16;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = CFG_IDX_W'(1);
  localparam logic [7:0] SYNC_FIRST_RST  = 8'd36;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd64;

  // Result event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_ACCEPT = 2'd1;
  localparam logic [1:0] EV_REJECT = 2'd2;

  // Classified byte as it sits in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       first_hit;
    logic       second_hit;
  } gbfd_item_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic       valid;
    gbfd_item_t item;
  } gbfd_qhead_t;

  // CRC-16 poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/gbfd_ifs.sv]
// Valid/ready channel interfaces: received bytes, frame results, register writes.
// Depends on gbfd_pkg.
`default_nettype none

interface gbfd_byte_if import gbfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbfd_res_if import gbfd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic        in_frame;
  logic [8:0]  byte_position;
  logic [15:0] block_id;
  logic [15:0] frame_length;
  modport source (output valid, output event_res, output in_frame, output byte_position,
                  output block_id, output frame_length, input ready);
  modport sink   (input valid, input event_res, input in_frame, input byte_position,
                  input block_id, input frame_length, output ready);
endinterface

interface gbfd_cfg_if import gbfd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/gbfd_front.sv]
// Front end: sync registers, byte classification and a two-entry queue.
// Depends on gbfd_pkg and gbfd_ifs.
`default_nettype none

module gbfd_front import gbfd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  gbfd_byte_if.sink  rx,
  gbfd_cfg_if.sink   cfg,
  output gbfd_qhead_t qhead,
  input  wire logic  pop
);

  logic [7:0] sync_first;
  logic [7:0] sync_second;

  gbfd_item_t q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic       push;
  gbfd_item_t in_item;

  // Register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SYNC_FIRST:  sync_first  <= cfg.data[7:0];
        CFG_SYNC_SECOND: sync_second <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Classify against both sync values on the way in
  always_comb begin
    in_item.data       = rx.rx_byte;
    in_item.first_hit  = (rx.rx_byte == sync_first);
    in_item.second_hit = (rx.rx_byte == sync_second);
  end

  assign rx.ready = (count != 2'd2);
  assign push     = rx.valid && rx.ready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign qhead.valid = (count != 2'd0);
  assign qhead.item  = q_mem[rd_ptr];

endmodule

`default_nettype wire

[src/gbfd_back.sv]
// Back end: sync/frame state machine, field capture, running CRC, result register.
// Depends on gbfd_pkg and gbfd_ifs.
`default_nettype none

module gbfd_back import gbfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire gbfd_qhead_t qhead,
  output logic             pop,
  gbfd_res_if.source       res
);

  typedef enum logic [1:0] {PH_HUNT, PH_SECOND, PH_FRAME} phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   position, position_next;
  logic [15:0]        received_check;
  logic [15:0]        id_field;
  logic [15:0]        length_field;
  logic [15:0]        running_check;
  logic [15:0]        short_checks [3];

  logic        out_valid;
  logic [1:0]  out_event;
  logic        out_in_frame;
  logic [8:0]  out_pos;
  logic [15:0] out_bid;
  logic [15:0] out_len;

  // Per-byte computed values
  logic [7:0]       b;
  logic [POS_W-1:0] p;
  logic [POS_W-1:0] n;
  logic [15:0]      rc_st, id_st, len_st, run_st, crc_in, crc_out, chk;
  logic             do_crc, store, end_hit, ok;
  logic [1:0]       sidx;
  logic [1:0]       ev_next;
  logic             inf_next;
  logic [8:0]       pos_next;
  logic [15:0]      bid_next, flen_next;
  logic             load;

  assign load = qhead.valid && (!out_valid || res.ready);
  assign pop  = load;
  assign b    = qhead.item.data;

  // Store path: field capture and CRC for the byte at index p
  always_comb begin
    p      = (phase == PH_FRAME || phase == PH_SECOND) ? position : '0;
    n      = p + POS_W'(1);
    rc_st  = received_check;
    id_st  = id_field;
    len_st = length_field;
    if (p == POS_W'(2)) rc_st  = {8'h00, b};
    if (p == POS_W'(3)) rc_st  = {b, received_check[7:0]};
    if (p == POS_W'(4)) id_st  = {8'h00, b};
    if (p == POS_W'(5)) id_st  = {b, id_field[7:0]};
    if (p == POS_W'(6)) len_st = {8'h00, b};
    if (p == POS_W'(7)) len_st = {b, length_field[7:0]};
    crc_in  = (p == POS_W'(4)) ? 16'h0000 : running_check;
    crc_out = crc16_byte(crc_in, b);
    do_crc  = (p >= POS_W'(4)) && ((p < POS_W'(8)) || (CMP_W'(p) < CMP_W'(len_st)));
    run_st  = do_crc ? crc_out : running_check;
    // frame end and acceptance
    end_hit = ((n > POS_W'(7)) && (CMP_W'(n) >= CMP_W'(len_st)))
              || (CMP_W'(n) >= CMP_W'(MAX_FRAME));
    sidx    = len_st[1:0] - 2'd1;
    chk     = (len_st < 16'd8) ? short_checks[sidx] : run_st;
    ok      = (len_st > 16'd4) && (CMP_W'(len_st) <= CMP_W'(n)) && (chk == rc_st);
  end

  // Phase decisions and result fields
  always_comb begin
    phase_next    = phase;
    position_next = position;
    store         = 1'b0;
    ev_next       = EV_NONE;
    inf_next      = 1'b0;
    pos_next      = 9'd0;
    bid_next      = 16'h0000;
    flen_next     = 16'h0000;
    case (phase)
      PH_SECOND: begin
        if (qhead.item.second_hit) begin
          store         = 1'b1;
          phase_next    = PH_FRAME;
          position_next = n;
        end else begin
          phase_next    = PH_HUNT;
          position_next = '0;
        end
      end
      PH_FRAME: begin
        store         = 1'b1;
        position_next = n;
        if (end_hit) begin
          ev_next       = ok ? EV_ACCEPT : EV_REJECT;
          bid_next      = id_st;
          flen_next     = len_st;
          phase_next    = PH_HUNT;
          position_next = '0;
        end
      end
      default: begin
        phase_next    = PH_HUNT;
        position_next = '0;
        if (qhead.item.first_hit) begin
          store         = 1'b1;
          phase_next    = PH_SECOND;
          position_next = n;
        end
      end
    endcase
    if (store) begin
      inf_next = 1'b1;
      pos_next = 9'(p);
    end
  end

  // State, frame fields and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      position  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) out_valid <= 1'b0;
      if (load) begin
        phase     <= phase_next;
        position  <= position_next;
        out_valid <= 1'b1;
      end
    end
    if (load) begin
      out_event    <= ev_next;
      out_in_frame <= inf_next;
      out_pos      <= pos_next;
      out_bid      <= bid_next;
      out_len      <= flen_next;
      if (store) begin
        received_check <= rc_st;
        id_field       <= id_st;
        length_field   <= len_st;
        running_check  <= run_st;
        if (p == POS_W'(4)) short_checks[0] <= run_st;
        if (p == POS_W'(5)) short_checks[1] <= run_st;
        if (p == POS_W'(6)) short_checks[2] <= run_st;
      end
    end
  end

  assign res.valid         = out_valid;
  assign res.event_res     = out_event;
  assign res.in_frame      = out_in_frame;
  assign res.byte_position = out_pos;
  assign res.block_id      = out_bid;
  assign res.frame_length  = out_len;

endmodule

`default_nettype wire

[src/gnss_binary_frame_deframer.sv]
// Binary frame deframer: one received byte in, one result beat out, at one byte
// per clock sustained while the result channel is not stalled. A byte is classified
// against the two sync registers and queued (two entries); the back end then advances
// the hunt/frame state, captures CRC, id and length fields and updates the CRC-16
// (poly 0x1021, init 0) for each byte, and registers the result beat. Sync registers
// are written through the configuration channel (index 0 first sync, index 1 second
// sync).
// Depends on gbfd_pkg, gbfd_ifs, gbfd_front and gbfd_back.
`default_nettype none

module gnss_binary_frame_deframer import gbfd_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  gbfd_byte_if.sink  rx,
  gbfd_res_if.source res,
  gbfd_cfg_if.sink   cfg
);

  gbfd_qhead_t qhead;
  logic        pop;

  gbfd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .cfg   (cfg),
    .qhead (qhead),
    .pop   (pop)
  );

  gbfd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .qhead (qhead),
    .pop   (pop),
    .res   (res)
  );

  // A beat taken in leaves the queue non-empty on the next cycle
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    rx.valid && rx.ready |=> qhead.valid)
    else $error("queue empty after accepted byte");

  // A completed frame is always reported on a frame byte
  a_event_in_frame: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.event_res != EV_NONE) |-> res.in_frame)
    else $error("frame event on a non-frame byte");

  // Bytes outside a frame carry no position and no event
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.in_frame |-> (res.byte_position == 9'd0) && (res.event_res == EV_NONE))
    else $error("stray fields on a non-frame byte");

endmodule

`default_nettype wire
